// File: src/rdsc_pkg.sv
// Shared types, constants and helpers for the radix digit string converter.
// No dependencies; used by rdsc_div, radix_digit_string_converter_top and the bench.
package rdsc_pkg;

  // radix limits and digit alphabet bases
  localparam logic [5:0] RADIX_MIN    = 6'd2;
  localparam logic [5:0] RADIX_MAX    = 6'd62;
  localparam logic [5:0] RADIX_RESET  = 6'd10;
  localparam logic [6:0] CHAR_ZERO    = 7'h30;
  localparam logic [6:0] CHAR_UPPER_A = 7'h41;
  localparam logic [6:0] CHAR_LOWER_A = 7'h61;
  localparam logic [6:0] CHAR_NONE    = 7'h00;

  // digit count limit for a non-negative 63-bit value
  localparam logic [6:0] MAX_DIGITS = 7'd63;

  // divider geometry: quotient bits resolved per cycle
  localparam int unsigned DIV_BITS      = 4;
  localparam int unsigned DIV_WIDTH     = 64;
  localparam int unsigned DIV_CYCLES    = DIV_WIDTH / DIV_BITS;
  localparam int unsigned DIV_CNT_W     = $clog2(DIV_CYCLES);

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SINGLE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_READ,
    ST_EMIT
  } state_e;

  // request into the shared divider
  typedef struct packed {
    logic        start;
    logic [62:0] dividend;
    logic [5:0]  divisor;
  } div_req_t;

  // result back from the shared divider
  typedef struct packed {
    logic        done;
    logic [62:0] quotient;
    logic [5:0]  remainder;
  } div_rsp_t;

  // digit value 0..61 to its ascii code
  function automatic logic [6:0] to_ascii(logic [5:0] d);
    logic [6:0] dx;
    dx = {1'b0, d};
    if (d < 6'd10) begin
      return CHAR_ZERO + dx;
    end else if (d < 6'd36) begin
      return CHAR_UPPER_A + (dx - 7'd10);
    end else begin
      return CHAR_LOWER_A + (dx - 7'd36);
    end
  endfunction

endpackage

// File: src/rdsc_div.sv
// Iterative restoring divider: 63-bit dividend by 6-bit radix, a few bits per cycle.
// Depends on rdsc_pkg for geometry and the request/response structs.
module rdsc_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rdsc_pkg::div_req_t req_i,
  output rdsc_pkg::div_rsp_t rsp_o
);

  localparam int unsigned W = rdsc_pkg::DIV_WIDTH;
  localparam int unsigned B = rdsc_pkg::DIV_BITS;

  logic [W-1:0]                   sh_q, sh_d;
  logic [5:0]                     rem_q, rem_d;
  logic [5:0]                     dvs_q;
  logic [rdsc_pkg::DIV_CNT_W-1:0] cnt_q;
  logic                           busy_q, done_q;

  // a few dependent compare-subtract steps on the narrow remainder
  always_comb begin
    logic [6:0]   r;
    logic [B-1:0] qb;
    r  = {1'b0, rem_q};
    qb = '0;
    for (int j = 0; j < B; j++) begin
      r = {r[5:0], sh_q[W-1-j]};
      if (r >= {1'b0, dvs_q}) begin
        r         = r - {1'b0, dvs_q};
        qb[B-1-j] = 1'b1;
      end
    end
    rem_d = r[5:0];
    sh_d  = {sh_q[W-B-1:0], qb};
  end

  // control: busy flag, step counter, done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == rdsc_pkg::DIV_CNT_W'(rdsc_pkg::DIV_CYCLES - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath: shift register turns into the quotient
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      sh_q  <= {1'b0, req_i.dividend};
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      sh_q  <= sh_d;
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = sh_q[62:0];
  assign rsp_o.remainder = rem_q;

endmodule

// File: src/rdsc_digit_store.sv
// Remainder store: one write port and one registered read port.
// No package dependencies.
module rdsc_digit_store #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [5:0]               wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [5:0]               rdata_o
);

  logic [5:0] mem [DEPTH];
  logic [5:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/radix_digit_string_converter_top.sv
// Top level of the radix digit string converter: sequencer, output register, assertions.
// Depends on rdsc_pkg, rdsc_div and rdsc_digit_store.

// Converts one non-negative 64-bit value per transaction into its digit string
// in the configured radix (2..62, alphabet 0-9 A-Z a-z), one ascii character
// per output transaction, most significant first, last_digit_o on the final one.
// Zero gives the single character '0' whatever the radix; a negative value or
// a radix outside 2..62 gives one transaction with error_o set. Each digit costs
// one pass of the shared divider, and each character is then read back from the
// remainder store. The input side stalls until the previous number is fully
// handed to the output register. The radix is written through cfg_we_i while
// idle; the user must keep to this, as the block itself does not enforce it.
module radix_digit_string_converter_top #(
  parameter int unsigned DIGIT_SLOTS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [6:0]  digit_char_o,
  output logic        last_digit_o,
  output logic        error_o
);

  localparam int unsigned IDX_W = $clog2(DIGIT_SLOTS);

  rdsc_pkg::state_e   state_q, state_d;
  logic [5:0]         radix_q;
  logic [6:0]         cnt_q, cnt_d;
  logic [6:0]         idx_q, idx_d;
  logic [62:0]        quot_q, quot_d;
  logic               out_valid_q, out_valid_d;
  logic [6:0]         out_char_q, out_char_d;
  logic               out_last_q, out_last_d;
  logic               out_err_q, out_err_d;
  logic               single_err_q, single_err_d;
  logic               in_take, out_free, radix_ok;
  rdsc_pkg::div_req_t div_req;
  rdsc_pkg::div_rsp_t div_rsp;
  logic               st_we, st_re;
  logic [5:0]         st_rdata;

  assign in_take  = in_valid_i && (state_q == rdsc_pkg::ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign radix_ok = (radix_q >= rdsc_pkg::RADIX_MIN) && (radix_q <= rdsc_pkg::RADIX_MAX);

  // radix register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= rdsc_pkg::RADIX_RESET;
    end else if (cfg_we_i) begin
      radix_q <= cfg_wdata_i;
    end
  end

  // shared divider and remainder store
  rdsc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  rdsc_digit_store #(
    .DEPTH (DIGIT_SLOTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (cnt_q[IDX_W-1:0]),
    .wdata_i (div_rsp.remainder),
    .re_i    (st_re),
    .raddr_i (idx_q[IDX_W-1:0]),
    .rdata_o (st_rdata)
  );

  // sequencer next state and output register loading
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    idx_d        = idx_q;
    quot_d       = quot_q;
    single_err_d = single_err_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_char_d   = out_char_q;
    out_last_d   = out_last_q;
    out_err_d    = out_err_q;
    div_req.start    = 1'b0;
    div_req.dividend = quot_q;
    div_req.divisor  = radix_q;
    st_we = 1'b0;
    st_re = 1'b0;
    case (state_q)
      rdsc_pkg::ST_IDLE: begin
        if (in_take) begin
          quot_d = value_i[62:0];
          if (value_i == 64'd0) begin
            cnt_d        = 7'd1;
            single_err_d = 1'b0;
            state_d      = rdsc_pkg::ST_SINGLE;
          end else if (!radix_ok || value_i[63]) begin
            cnt_d        = 7'd0;
            single_err_d = 1'b1;
            state_d      = rdsc_pkg::ST_SINGLE;
          end else begin
            cnt_d   = 7'd0;
            state_d = rdsc_pkg::ST_DIV_START;
          end
        end
      end
      rdsc_pkg::ST_SINGLE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = single_err_q ? rdsc_pkg::CHAR_NONE : rdsc_pkg::CHAR_ZERO;
          out_last_d  = 1'b1;
          out_err_d   = single_err_q;
          state_d     = rdsc_pkg::ST_IDLE;
        end
      end
      rdsc_pkg::ST_DIV_START: begin
        div_req.start = 1'b1;
        state_d       = rdsc_pkg::ST_DIV_WAIT;
      end
      rdsc_pkg::ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          st_we  = 1'b1;
          cnt_d  = cnt_q + 7'd1;
          quot_d = div_rsp.quotient;
          if (div_rsp.quotient == 63'd0 || cnt_d == rdsc_pkg::MAX_DIGITS) begin
            idx_d   = cnt_q;
            state_d = rdsc_pkg::ST_READ;
          end else begin
            state_d = rdsc_pkg::ST_DIV_START;
          end
        end
      end
      rdsc_pkg::ST_READ: begin
        st_re   = 1'b1;
        state_d = rdsc_pkg::ST_EMIT;
      end
      rdsc_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = rdsc_pkg::to_ascii(st_rdata);
          out_last_d  = (idx_q == 7'd0);
          out_err_d   = 1'b0;
          if (idx_q == 7'd0) begin
            state_d = rdsc_pkg::ST_IDLE;
          end else begin
            idx_d   = idx_q - 7'd1;
            state_d = rdsc_pkg::ST_READ;
          end
        end
      end
      default: begin
        state_d = rdsc_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rdsc_pkg::ST_IDLE;
      cnt_q       <= '0;
      quot_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      quot_q      <= quot_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    single_err_q <= single_err_d;
    out_char_q   <= out_char_d;
    out_last_q   <= out_last_d;
    out_err_q    <= out_err_d;
  end

  assign in_stall_o   = (state_q != rdsc_pkg::ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign digit_char_o = out_char_q;
  assign last_digit_o = out_last_q;
  assign error_o      = out_err_q;

  // an accepted transaction makes the input side busy next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accepting a transaction");

  // an error transaction is always a single last character of code zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> last_digit_o && (digit_char_o == rdsc_pkg::CHAR_NONE))
    else $error("error transaction is not a lone null character");

  // the divider only finishes while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == rdsc_pkg::ST_DIV_WAIT))
    else $error("divider finished outside of the wait state");

  // the digit count never passes the limit for a 63-bit value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= rdsc_pkg::MAX_DIGITS)
    else $error("digit count beyond limit");

endmodule

// File: bench/testbench.sv
// Self-checking bench for radix_digit_string_converter_top: random and directed numbers
// against a cycle-free digit predictor. Depends on rdsc_pkg and the converter RTL.
module testbench;

  localparam int unsigned TIMEOUT_UNITS = 60_000_000;
  localparam int unsigned PHASE_ITEMS   = 30;
  localparam int unsigned RAND_PHASES   = 12;

  // one output character as expected from the block
  typedef struct packed {
    logic [6:0] ch;
    logic       last;
    logic       err;
  } char_t;

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [5:0]  cfg_wdata_i = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [63:0] value_i     = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [6:0]  digit_char_o;
  logic        last_digit_o;
  logic        error_o;

  // predictor state: radix copy, remainder slots, digit count
  logic [5:0]  radix_now   = rdsc_pkg::RADIX_RESET;
  logic [5:0]  slot_mem [64];
  logic [6:0]  digits_held = '0;

  logic [63:0] pending_values [$];
  char_t       chars_due [$];
  char_t       want;
  logic        in_taken    = 1'b0;
  logic        out_taken   = 1'b0;
  logic        steady      = 1'b0;
  int unsigned send_wait   = 0;
  int unsigned hold_left   = 0;
  int unsigned fail_count  = 0;

  radix_digit_string_converter_top uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .digit_char_o (digit_char_o),
    .last_digit_o (last_digit_o),
    .error_o      (error_o)
  );

  // clock, period 12
  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // digit value to its character in the 0-9 A-Z a-z alphabet
  function automatic logic [6:0] digit_ascii(input logic [5:0] d);
    logic [6:0] wide;
    wide = {1'b0, d};
    if (d < 6'd10) begin
      return rdsc_pkg::CHAR_ZERO + wide;
    end else if (d < 6'd36) begin
      return rdsc_pkg::CHAR_UPPER_A + wide - 7'd10;
    end
    return rdsc_pkg::CHAR_LOWER_A + wide - 7'd36;
  endfunction

  function automatic void push_char(input logic [6:0] ch, input logic last, input logic err);
    char_t c;
    c.ch   = ch;
    c.last = last;
    c.err  = err;
    chars_due.push_back(c);
  endfunction

  // expected character string of one number in the current radix
  function automatic void predict_digits(input logic [63:0] number);
    logic [62:0] quot;
    logic [62:0] rem;
    logic [6:0]  cnt;
    if (number == '0) begin
      slot_mem[0] = '0;
      digits_held = 7'd1;
      push_char(rdsc_pkg::CHAR_ZERO, 1'b1, 1'b0);
      return;
    end
    if (radix_now < rdsc_pkg::RADIX_MIN || radix_now > rdsc_pkg::RADIX_MAX ||
        number[63]) begin
      digits_held = '0;
      push_char(rdsc_pkg::CHAR_NONE, 1'b1, 1'b1);
      return;
    end
    quot = number[62:0];
    cnt  = '0;
    while (quot != '0 && cnt < rdsc_pkg::MAX_DIGITS) begin
      rem = quot % radix_now;
      slot_mem[cnt[5:0]] = rem[5:0];
      quot = quot / radix_now;
      cnt++;
    end
    digits_held = cnt;
    for (int i = int'(cnt) - 1; i >= 0; i--) begin
      push_char(digit_ascii(slot_mem[i[5:0]]), i == 0, 1'b0);
    end
  endfunction

  // per-transaction idle draw, none at all in steady phases
  function automatic int unsigned pick_wait();
    if (steady || $urandom_range(0, 3) == 0) begin
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  // mostly valid bases, sometimes an out-of-range one
  function automatic logic [5:0] rand_radix();
    if ($urandom_range(0, 4) != 0) begin
      return 6'($urandom_range(rdsc_pkg::RADIX_MIN, rdsc_pkg::RADIX_MAX));
    end
    case ($urandom_range(0, 2))
      0:       return 6'd0;
      1:       return 6'd1;
      default: return 6'd63;
    endcase
  endfunction

  // zero, negatives, full-scale and numbers of random bit length
  function automatic logic [63:0] rand_number();
    logic [63:0] v;
    int unsigned kind;
    int unsigned len;
    kind = $urandom_range(0, 99);
    v    = {$urandom, $urandom};
    if (kind < 8) begin
      v = '0;
    end else if (kind < 18) begin
      v[63] = 1'b1;
    end else if (kind < 22) begin
      v = 64'h7FFF_FFFF_FFFF_FFFF;
    end else begin
      len = $urandom_range(1, 63);
      v   = v & ((64'd1 << len) - 64'd1);
      v[len - 1] = 1'b1;
    end
    return v;
  endfunction

  // input side: accepted transactions feed the predictor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        predict_digits(value_i);
      end
    end
  end

  // driver: launches pending numbers after a random gap
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_wait = 0;
    end else if (!in_valid_i || in_taken) begin
      if (in_valid_i) begin
        send_wait = pick_wait();
      end
      if (send_wait == 0 && pending_values.size() != 0) begin
        value_i    <= pending_values.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        if (send_wait != 0) begin
          send_wait--;
        end
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor: compare each output transaction with the oldest expected character
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_taken <= 1'b0;
    end else begin
      out_taken <= out_valid_o && !out_stall_i;
      if (out_valid_o && !out_stall_i) begin
        if (chars_due.size() == 0) begin
          $display("%0t: unexpected character, expected none, actual %h last %b error %b",
                   $time, digit_char_o, last_digit_o, error_o);
          fail_count++;
        end else begin
          want = chars_due.pop_front();
          if (digit_char_o !== want.ch) begin
            $display("%0t: digit_char mismatch, expected %h, actual %h",
                     $time, want.ch, digit_char_o);
            fail_count++;
          end
          if (last_digit_o !== want.last) begin
            $display("%0t: last_digit mismatch, expected %b, actual %b",
                     $time, want.last, last_digit_o);
            fail_count++;
          end
          if (error_o !== want.err) begin
            $display("%0t: error mismatch, expected %b, actual %b",
                     $time, want.err, error_o);
            fail_count++;
          end
        end
      end
    end
  end

  // receiver stall: random hold after each accepted character
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_taken) begin
        hold_left = pick_wait();
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // wait until every pending number is sent and every character has come back
  task automatic drain();
    @(posedge clk_i);
    while (pending_values.size() != 0 || in_valid_i || chars_due.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic set_radix(input logic [5:0] r);
    drain();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= r;
    radix_now = r;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // stimulus: directed corners, then random phases
  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset radix 10: zero, small, full-scale, negatives
    pending_values.push_back(64'd0);
    pending_values.push_back(64'd1);
    pending_values.push_back(64'd9);
    pending_values.push_back(64'd10);
    pending_values.push_back(64'h7FFF_FFFF_FFFF_FFFF);
    pending_values.push_back(64'hFFFF_FFFF_FFFF_FFFF);
    pending_values.push_back(64'h8000_0000_0000_0000);

    // binary: longest string
    set_radix(rdsc_pkg::RADIX_MIN);
    pending_values.push_back(64'h7FFF_FFFF_FFFF_FFFF);
    pending_values.push_back(64'd1);
    pending_values.push_back(64'd0);

    // base 62: alphabet boundaries and the top digit
    set_radix(rdsc_pkg::RADIX_MAX);
    pending_values.push_back(64'd61);
    pending_values.push_back(64'd62);
    pending_values.push_back(64'd35);
    pending_values.push_back(64'd36);
    pending_values.push_back(64'h7FFF_FFFF_FFFF_FFFF);

    // invalid bases: zero still converts, anything else is rejected
    set_radix(6'd63);
    pending_values.push_back(64'd0);
    pending_values.push_back(64'd5);
    set_radix(6'd0);
    pending_values.push_back(64'd7);
    pending_values.push_back(64'hFFFF_FFFF_FFFF_FFFF);
    set_radix(6'd1);
    pending_values.push_back(64'd0);
    pending_values.push_back(64'd1);

    for (int p = 0; p < RAND_PHASES; p++) begin
      set_radix(rand_radix());
      steady = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pending_values.push_back(rand_number());
      end
    end

    drain();
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_UNITS);
    $display("Test completed with failures");
    $finish;
  end

endmodule
